// ===== src/binary_and_text_line_deframer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers on clk_i / rst_ni, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BINARY_AND_TEXT_LINE_DEFRAMER_CORE_DEFINES_SVH
`define BINARY_AND_TEXT_LINE_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define BATLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define BATLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BATLD_ASSERT(lbl, prop, msg)
`define BATLD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/batld_pkg.sv =====
// ----------------------------------------------------------------------------
// Deframer package
// Sync and line characters, end kinds and the frame state and result types.
// ----------------------------------------------------------------------------
package batld_pkg;

  localparam logic [7:0]  SyncFirst    = 8'hA0;
  localparam logic [7:0]  SyncSecond   = 8'hA1;
  localparam logic [7:0]  CharCr       = 8'h0D;
  localparam logic [7:0]  CharLf       = 8'h0A;
  localparam logic [16:0] BinLfOffset  = 17'd6;
  localparam logic [15:0] MaxLenReset  = 16'd4096;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_BINARY   = 2'd1,
    KIND_TEXT     = 2'd2,
    KIND_OVERFLOW = 2'd3
  } end_kind_e;

  typedef struct packed {
    logic [15:0] byte_count;
    logic        header_seen;
    logic [7:0]  previous_byte;
    logic [7:0]  first_byte;
    logic [7:0]  length_high;
    logic [7:0]  length_low;
  } frame_state_t;

  localparam frame_state_t FrameStateClear = '{
    byte_count:    16'd0,
    header_seen:   1'b0,
    previous_byte: 8'd0,
    first_byte:    8'd0,
    length_high:   8'd0,
    length_low:    8'd0
  };

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_position;
    logic        restart;
    logic        frame_last;
    end_kind_e   end_kind;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ===== src/batld_step.sv =====
// ----------------------------------------------------------------------------
// Deframer byte step
// Next frame state and result for one byte, from the current frame state.
// ----------------------------------------------------------------------------
module batld_step import batld_pkg::*; (
  input  logic [7:0]   rx_byte_i,
  input  logic [15:0]  max_frame_len_i,
  input  frame_state_t state_i,
  output frame_state_t state_o,
  output result_t      result_o
);

  logic [15:0] limit;
  logic [15:0] pos;
  logic [16:0] pos_inc;
  logic [16:0] bin_lf_pos;
  logic        is_restart;
  logic        is_crlf;
  end_kind_e   kind;
  frame_state_t nxt;

  assign limit      = max_frame_len_i - 16'd1;
  assign pos        = state_i.byte_count;
  assign pos_inc    = {1'b0, pos} + 17'd1;
  assign bin_lf_pos = {1'b0, state_i.length_high, state_i.length_low} + BinLfOffset;

  // Detect header re-anchor and line end
  assign is_restart = (pos != 16'd0) && !state_i.header_seen &&
                      (rx_byte_i == SyncSecond) && (state_i.previous_byte == SyncFirst);
  assign is_crlf    = (pos != 16'd0) && (rx_byte_i == CharLf) &&
                      (state_i.previous_byte == CharCr);

  // Classify the byte and advance the frame state
  always_comb begin
    nxt  = state_i;
    kind = KIND_NONE;
    if (is_restart) begin
      nxt.byte_count    = 16'd2;
      nxt.header_seen   = 1'b1;
      nxt.previous_byte = rx_byte_i;
      nxt.first_byte    = SyncFirst;
      nxt.length_high   = 8'd0;
      nxt.length_low    = 8'd0;
    end else begin
      if (is_crlf) begin
        if (state_i.first_byte == SyncFirst) begin
          if ({1'b0, pos} == bin_lf_pos) begin
            kind = KIND_BINARY;
          end else begin
            nxt.header_seen = 1'b0;
          end
        end else begin
          kind = KIND_TEXT;
        end
      end
      if (kind == KIND_NONE) begin
        unique case (pos)
          16'd0:   nxt.first_byte  = rx_byte_i;
          16'd2:   nxt.length_high = rx_byte_i;
          16'd3:   nxt.length_low  = rx_byte_i;
          default: ;
        endcase
        nxt.previous_byte = rx_byte_i;
        nxt.byte_count    = pos_inc[15:0];
        if (pos_inc >= {1'b0, limit}) begin
          kind = KIND_OVERFLOW;
        end
      end
    end
    // Drop the frame once it closes
    state_o = (kind != KIND_NONE) ? FrameStateClear : nxt;
  end

  // Build the result
  always_comb begin
    result_o.out_byte      = rx_byte_i;
    result_o.byte_position = is_restart ? 16'd1 : pos;
    result_o.restart       = is_restart;
    result_o.frame_last    = (kind != KIND_NONE);
    result_o.end_kind      = kind;
    result_o.frame_length  = (kind != KIND_NONE) ? pos_inc[15:0] : 16'd0;
  end

endmodule

// ===== src/binary_and_text_line_deframer_core.sv =====
// ----------------------------------------------------------------------------
// Binary and text line deframer
// Frames a byte stream of A0 A1 binary messages and CR LF text lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_ready_o carry one received byte per request.
//   Output channel: out_valid_o / out_ready_i carry one result per byte: the
//   byte, its position in the frame, the restart flag, and on the closing byte
//   frame_last, end_kind and frame_length.
//   Configuration: cfg_we_i writes cfg_wdata_i into max_frame_len; write only
//   while no request is in flight.
//   Path: a byte accepted is held in the input register, then processed into
//   the result register once that register is free or being emptied, and its
//   result is offered from there.
//   Throughput: one byte per cycle while the receiver takes results, set by
//   the single step from the frame state register to the result register.
//   Reset clears the frame state, both valid flags and sets max_frame_len to
//   4096. When the receiver stalls the result register holds; the input
//   register still takes one more byte, then in_ready_o drops until the
//   result is taken.
// ----------------------------------------------------------------------------
`include "binary_and_text_line_deframer_core_defines.svh"

module binary_and_text_line_deframer_core import batld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [15:0] byte_position_o,
  output logic        restart_o,
  output logic        frame_last_o,
  output logic [1:0]  end_kind_o,
  output logic [15:0] frame_length_o
);

  logic [15:0]  max_len_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  result_t      out_q;
  frame_state_t state_q;
  frame_state_t state_d;
  result_t      result_d;
  logic         advance;

  // Move a byte on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  batld_step u_step (
    .rx_byte_i       (in_byte_q),
    .max_frame_len_i (max_len_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  // Hold the frame length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame state, advanced once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrameStateClear;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_q.out_byte;
  assign byte_position_o = out_q.byte_position;
  assign restart_o       = out_q.restart;
  assign frame_last_o    = out_q.frame_last;
  assign end_kind_o      = out_q.end_kind;
  assign frame_length_o  = out_q.frame_length;

  // Closing byte empties the frame state
  `BATLD_ASSERT(a_close_clears, advance && result_d.frame_last |=> state_q.byte_count == 16'd0, "frame state not cleared after close")
  // Restart re-anchors at position one and never closes
  `BATLD_ASSERT(a_restart_pos, out_valid_o && restart_o |-> byte_position_o == 16'd1 && !frame_last_o, "restart result malformed")
  // Closed frame length follows its last position
  `BATLD_ASSERT(a_close_len, out_valid_o && frame_last_o |-> frame_length_o == byte_position_o + 16'd1 && end_kind_o != KIND_NONE, "frame length mismatch on close")
  // Nothing is processed without a held byte
  `BATLD_ASSERT_ALWAYS(a_advance_src, advance |-> in_valid_q, "step advanced without input")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Feeds byte streams of binary messages, text lines and noise through the
// deframer under several buffer sizes. It predicts each echoed result in step
// with the accepted bytes and compares every field. Both handshakes stall at
// random.
// ----------------------------------------------------------------------------
module testbench;
  import batld_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int IdlePercent = 26;
  localparam int CycleLimit  = 1000000;
  localparam int ReportLimit = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic [15:0] byte_position_o;
  logic        restart_o;
  logic        frame_last_o;
  logic [1:0]  end_kind_o;
  logic [15:0] frame_length_o;

  // Predicted frame state and buffer size
  frame_state_t framing;
  logic [15:0]  buffer_size = MaxLenReset;
  result_t      echo_q[$];

  bit calm = 1'b0;
  int mismatches = 0;
  int bytes_sent = 0;
  int binary_closes = 0;
  int text_closes = 0;
  int overflow_closes = 0;
  int restarts = 0;
  int cycle_count = 0;

  binary_and_text_line_deframer_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_position_o(byte_position_o),
    .restart_o      (restart_o),
    .frame_last_o   (frame_last_o),
    .end_kind_o     (end_kind_o),
    .frame_length_o (frame_length_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Work out the echo of one byte and advance the predicted frame state
  function automatic result_t deframe_byte(input logic [7:0] b);
    logic [15:0] limit;
    logic [16:0] pos;
    logic [16:0] msg_len;
    end_kind_e   kind;
    result_t     r;
    limit = buffer_size - 16'd1;
    pos = {1'b0, framing.byte_count};
    kind = KIND_NONE;
    r.out_byte = b;
    r.byte_position = framing.byte_count;
    r.restart = 1'b0;
    r.frame_length = '0;
    if (pos != 0 && !framing.header_seen && b == SyncSecond &&
        framing.previous_byte == SyncFirst) begin
      // re-anchor as A0 A1, length bytes still to come
      r.byte_position = 16'd1;
      r.restart = 1'b1;
      framing.first_byte = SyncFirst;
      framing.length_high = '0;
      framing.length_low = '0;
      framing.header_seen = 1'b1;
      framing.byte_count = 16'd2;
      framing.previous_byte = b;
    end else begin
      if (pos != 0 && b == CharLf && framing.previous_byte == CharCr) begin
        if (framing.first_byte == SyncFirst) begin
          msg_len = {1'b0, framing.length_high, framing.length_low};
          if (pos == msg_len + BinLfOffset) kind = KIND_BINARY;
          else framing.header_seen = 1'b0;
        end else begin
          kind = KIND_TEXT;
        end
      end
      if (kind == KIND_NONE) begin
        case (pos)
          17'd0: framing.first_byte = b;
          17'd2: framing.length_high = b;
          17'd3: framing.length_low = b;
          default: ;
        endcase
        framing.previous_byte = b;
        framing.byte_count = pos[15:0] + 16'd1;
        if (pos + 17'd1 >= {1'b0, limit}) kind = KIND_OVERFLOW;
      end
    end
    r.end_kind = kind;
    r.frame_last = (kind != KIND_NONE);
    if (kind != KIND_NONE) begin
      r.frame_length = r.byte_position + 16'd1;
      framing = FrameStateClear;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      // keep the log readable when the block is badly off
      if (mismatches <= ReportLimit)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Check each result against the oldest echo and drive the receiver stalls
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (echo_q.size() == 0) begin
        mismatches++;
        $error("result with no request outstanding: byte %0h", out_byte_o);
      end else begin
        want = echo_q.pop_front();
        compare_field("out_byte", 16'(want.out_byte), 16'(out_byte_o));
        compare_field("byte_position", want.byte_position, byte_position_o);
        compare_field("restart", 16'(want.restart), 16'(restart_o));
        compare_field("frame_last", 16'(want.frame_last), 16'(frame_last_o));
        compare_field("end_kind", 16'(want.end_kind), 16'(end_kind_o));
        compare_field("frame_length", want.frame_length, frame_length_o);
        if (want.restart) restarts++;
        case (want.end_kind)
          KIND_BINARY:   binary_closes++;
          KIND_TEXT:     text_closes++;
          KIND_OVERFLOW: overflow_closes++;
          default: ;
        endcase
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
  end

  // Offer one byte, idling first at random; valid stays high for the next one
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < IdlePercent) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    echo_q.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  // Drop valid and hold until every outstanding request has its result
  task automatic drain;
    in_valid_i <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_buffer_size(input logic [15:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    buffer_size = value;
  endtask

  // Frames under the reset buffer size: lines, a restarted binary message
  task automatic test_directed_frames;
    logic [7:0] stream[$];
    // lone LF at frame start, then CR LF closing a text line
    stream = '{CharLf, CharCr, CharLf};
    // field extremes in a text line
    stream = {stream, 8'hFF, 8'h00, CharCr, CharLf};
    // noise, then A0 A1 restart and an empty binary message
    stream = {stream, 8'h55, SyncFirst, SyncSecond, 8'h00, 8'h00, 8'h7E,
              CharCr, CharLf};
    foreach (stream[i]) send_byte(stream[i]);
  endtask

  // Short A0 frame with an early CR LF, then overflow at the small sizes
  task automatic test_overflow_sizes;
    logic [7:0] stream[$];
    write_buffer_size(16'd8);
    stream = '{SyncFirst, CharCr, CharLf, 8'h11, 8'h22, 8'h33, 8'h44};
    foreach (stream[i]) send_byte(stream[i]);
    write_buffer_size(16'd3);
    send_byte(8'h31);
    send_byte(8'h32);
    write_buffer_size(16'd1);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    write_buffer_size(16'd2);
    send_byte(8'h42);
    send_byte(CharLf);
  endtask

  // Mostly well-formed messages and lines with random content, some broken
  task automatic test_random_stream(input int count, input logic [15:0] size,
                                    input bit quiet);
    logic [7:0]  stream[$];
    logic [15:0] msg_len;
    int          sent_here;
    int          pick;
    int          span;
    write_buffer_size(size);
    calm = quiet;
    sent_here = 0;
    while (sent_here < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        msg_len = 16'($urandom_range(24));
        stream = '{SyncFirst, SyncSecond, msg_len[15:8], msg_len[7:0]};
        // corrupt the length now and then
        if ($urandom_range(9) == 0) begin
          stream[2] = 8'($urandom_range(255));
          stream[3] = 8'($urandom_range(255));
        end
        repeat (msg_len) stream.push_back(8'($urandom_range(255)));
        stream.push_back(8'($urandom_range(255)));
        if ($urandom_range(9) != 0) stream = {stream, CharCr, CharLf};
      end else if (pick < 80) begin
        stream.delete();
        span = $urandom_range(30);
        repeat (span) begin
          if ($urandom_range(4) == 0) stream.push_back(8'($urandom_range(255)));
          else stream.push_back(8'($urandom_range(8'h7E, 8'h20)));
        end
        stream = {stream, CharCr, CharLf};
      end else begin
        stream.delete();
        span = $urandom_range(8, 1);
        repeat (span) begin
          case ($urandom_range(7))
            0: stream.push_back(SyncFirst);
            1: stream.push_back(SyncSecond);
            2: stream.push_back(CharCr);
            3: stream.push_back(CharLf);
            default: stream.push_back(8'($urandom_range(255)));
          endcase
        end
      end
      foreach (stream[i]) send_byte(stream[i]);
      sent_here += stream.size();
    end
    calm = 1'b0;
  endtask

  // A long open frame under the wrapped limit of a zero buffer size, no idling
  task automatic test_longest_frame;
    logic [7:0] b;
    write_buffer_size(16'd0);
    calm = 1'b1;
    repeat (32) begin
      b = 8'($urandom_range(255));
      if (b == CharLf || b == SyncSecond) b = 8'h55;
      send_byte(b);
    end
    calm = 1'b0;
  endtask

  initial begin
    framing = FrameStateClear;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_overflow_sizes();
    test_random_stream(150, MaxLenReset, 1'b0);
    test_random_stream(150, 16'd3, 1'b0);
    test_random_stream(150, 16'd65535, 1'b0);
    test_random_stream(150, 16'd12, 1'b0);
    test_random_stream(150, 16'd40, 1'b1);
    test_random_stream(80, 16'd30, 1'b0);
    test_longest_frame();
    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes across buffer sizes 0 to 65535 with random stalls.",
             bytes_sent);
    $display("Closes: %0d binary, %0d text, %0d overflow; %0d header restarts.",
             binary_closes, text_closes, overflow_closes, restarts);
    if (mismatches == 0 && echo_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Abandon a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/batld_pkg.sv
src/batld_step.sv
src/binary_and_text_line_deframer_core.sv
sim/testbench.sv
